@@ rtl/skf_pkg.sv @@
package skf_pkg;

    localparam int DATA_W    = 32;
    localparam int GAIN_W    = 17;
    localparam int QUOT_W    = GAIN_W - 1;
    localparam int ERR_W     = DATA_W + 1;
    localparam int PROD_W    = ERR_W + GAIN_W + 1;
    localparam int CFG_IDX_W = 3;

    localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(1) << QUOT_W;
    localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) << (QUOT_W - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_EST      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VAR      = CFG_IDX_W'(3);

    localparam logic [DATA_W-1:0] RST_PROCESS_NOISE = DATA_W'(655);
    localparam logic [DATA_W-1:0] RST_MEAS_NOISE    = DATA_W'(65536);
    localparam logic [DATA_W-1:0] RST_INIT_EST      = DATA_W'(0);
    localparam logic [DATA_W-1:0] RST_INIT_VAR      = DATA_W'(65536);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRED,
        S_SUM,
        S_DIV_GO,
        S_DIV,
        S_EST_GO,
        S_EST,
        S_VAR_GO,
        S_VAR,
        S_WB
    } t_state;

    function automatic logic [DATA_W-1:0] sat_add(
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] b
    );
        logic [DATA_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DATA_W] ? {DATA_W{1'b1}} : s[DATA_W-1:0];
    endfunction

endpackage

@@ rtl/skf_meas_if.sv @@
interface skf_meas_if;
    logic                                valid;
    logic                                ready;
    logic signed [skf_pkg::DATA_W-1:0]   measurement;
    logic                                restart;

    modport source (output valid, output measurement, output restart, input ready);
    modport sink   (input valid, input measurement, input restart, output ready);
endinterface

@@ rtl/skf_est_if.sv @@
interface skf_est_if;
    logic                                valid;
    logic                                ready;
    logic signed [skf_pkg::DATA_W-1:0]   estimate;
    logic        [skf_pkg::DATA_W-1:0]   variance;
    logic        [skf_pkg::GAIN_W-1:0]   gain;

    modport source (output valid, output estimate, output variance, output gain, input ready);
    modport sink   (input valid, input estimate, input variance, input gain, output ready);
endinterface

@@ rtl/scalar_kalman_filter.sv @@
// Scalar Kalman filter for barometric altitude.
// Input channel i_meas carries one measurement word (signed Q16.16) and a
// restart flag; a word is taken when valid and ready are both high. Output
// channel o_est carries the updated estimate, its variance and the gain
// (Q1.16, 65536 is one) for each measurement, one word per input word.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 process noise, 1 measurement noise, 2 initial estimate, 3 initial
// variance); other indexes are ignored, and a zero measurement noise is
// stored as one. Write only while no measurement is in flight.
// One measurement is processed at a time: a word is taken only in the idle
// state, so the next word waits until the last one has been through
// write-back. The work is done on shared arithmetic: a restoring divider
// for the gain and a shift-add multiplier run twice (estimate correction,
// then variance update), plus sequencer steps.
// Reset clears estimate and variance state to zero, loads the register
// defaults, empties the output register and holds i_meas.ready low.
// A result waits in the output register while o_est.ready is low; the next
// measurement is still taken and worked on, and its result waits in the
// write-back step until the output register frees up.
module scalar_kalman_filter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    skf_meas_if.sink                        i_meas,
    skf_est_if.source                       o_est,
    input  logic                            i_cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [skf_pkg::DATA_W-1:0]      i_cfg_data
);
    import skf_pkg::*;

    localparam int RND_W = PROD_W - QUOT_W;
    localparam int SUM_W = RND_W + 1;

    t_state r_state;
    t_state n_state;

    // configuration
    logic [DATA_W-1:0]        r_q;
    logic [DATA_W-1:0]        r_r;
    logic [DATA_W-1:0]        r_init_est;
    logic [DATA_W-1:0]        r_init_var;

    // filter state
    logic [DATA_W-1:0]        r_est;
    logic [DATA_W-1:0]        r_var;

    // working registers
    logic [DATA_W-1:0]        r_z;
    logic [DATA_W-1:0]        r_h;
    logic [DATA_W-1:0]        r_p;
    logic [DATA_W-1:0]        r_pred;
    logic [DATA_W-1:0]        r_s;
    logic [GAIN_W-1:0]        r_gain;
    logic [DATA_W-1:0]        r_new_est;
    logic [DATA_W-1:0]        r_new_var;

    // output register
    logic                     r_out_valid;
    logic [DATA_W-1:0]        r_out_est;
    logic [DATA_W-1:0]        r_out_var;
    logic [GAIN_W-1:0]        r_out_gain;

    logic                     in_accept;
    logic                     div_start;
    logic                     div_done;
    logic [GAIN_W-1:0]        div_quot;
    logic                     mul_start;
    logic [PROD_W-1:0]        mul_mcand;
    logic [GAIN_W-1:0]        mul_mplier;
    logic                     mul_done;
    logic [PROD_W-1:0]        mul_prod;
    logic                     wb_load;

    logic signed [ERR_W-1:0]  err;
    logic [PROD_W-1:0]        prod_rnd;
    logic signed [SUM_W-1:0]  est_sum;
    logic [DATA_W-1:0]        est_sat;
    logic [DATA_W-1:0]        var_sat;

    assign in_accept = i_meas.valid && i_meas.ready;

    assign err      = ERR_W'(signed'(r_z)) - ERR_W'(signed'(r_h));
    assign prod_rnd = mul_prod + ROUND_BIAS;
    assign est_sum  = SUM_W'(signed'(r_h)) + SUM_W'(signed'(prod_rnd[PROD_W-1:QUOT_W]));

    // clamp to the signed 32-bit range
    always_comb begin
        est_sat = est_sum[DATA_W-1:0];
        if (est_sum > SUM_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}))) begin
            est_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (est_sum < SUM_W'(signed'({1'b1, {(DATA_W-1){1'b0}}}))) begin
            est_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end
    end

    assign var_sat = (|prod_rnd[PROD_W-1:QUOT_W+DATA_W]) ? {DATA_W{1'b1}}
                                                         : prod_rnd[QUOT_W+DATA_W-1:QUOT_W];

    skf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_pred),
        .i_den   (r_s),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    skf_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mcand  (mul_mcand),
        .i_mplier (mul_mplier),
        .o_done   (mul_done),
        .o_prod   (mul_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        div_start  = 1'b0;
        mul_start  = 1'b0;
        mul_mcand  = PROD_W'(err);
        mul_mplier = r_gain;
        wb_load    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_PRED;
                end
            end
            S_PRED: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_EST_GO;
                end
            end
            S_EST_GO: begin
                mul_start = 1'b1;
                n_state   = S_EST;
            end
            S_EST: begin
                if (mul_done) begin
                    n_state = S_VAR_GO;
                end
            end
            S_VAR_GO: begin
                mul_start  = 1'b1;
                mul_mcand  = PROD_W'(r_pred);
                mul_mplier = GAIN_ONE - r_gain;
                n_state    = S_VAR;
            end
            S_VAR: begin
                if (mul_done) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                // hold until the output register is free
                if (!r_out_valid || o_est.ready) begin
                    wb_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q        <= RST_PROCESS_NOISE;
            r_r        <= RST_MEAS_NOISE;
            r_init_est <= RST_INIT_EST;
            r_init_var <= RST_INIT_VAR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PROCESS_NOISE: r_q <= i_cfg_data;
                CFG_MEAS_NOISE:    r_r <= (i_cfg_data == '0) ? DATA_W'(1) : i_cfg_data;
                CFG_INIT_EST:      r_init_est <= i_cfg_data;
                CFG_INIT_VAR:      r_init_var <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est       <= '0;
            r_var       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (wb_load) begin
                r_est       <= r_new_est;
                r_var       <= r_new_var;
                r_out_valid <= 1'b1;
            end else if (o_est.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_z <= i_meas.measurement;
            r_h <= i_meas.restart ? r_init_est : r_est;
            r_p <= i_meas.restart ? r_init_var : r_var;
        end
        if (r_state == S_PRED) begin
            r_pred <= sat_add(r_p, r_q);
        end
        if (r_state == S_SUM) begin
            r_s <= sat_add(r_pred, r_r);
        end
        if (r_state == S_DIV && div_done) begin
            r_gain <= div_quot;
        end
        if (r_state == S_EST && mul_done) begin
            r_new_est <= est_sat;
        end
        if (r_state == S_VAR && mul_done) begin
            r_new_var <= var_sat;
        end
        if (wb_load) begin
            r_out_est  <= r_new_est;
            r_out_var  <= r_new_var;
            r_out_gain <= r_gain;
        end
    end

    assign i_meas.ready   = i_rst_n && (r_state == S_IDLE);
    assign o_est.valid    = r_out_valid;
    assign o_est.estimate = r_out_est;
    assign o_est.variance = r_out_var;
    assign o_est.gain     = r_out_gain;

endmodule

@@ rtl/skf_div.sv @@
module skf_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [skf_pkg::DATA_W-1:0]   i_num,
    input  logic [skf_pkg::DATA_W-1:0]   i_den,
    output logic                         o_done,
    output logic [skf_pkg::GAIN_W-1:0]   o_quot
);
    import skf_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W:0]   r_rem;
    logic [DATA_W-1:0] r_den;
    logic [QUOT_W-1:0] r_quot;
    logic              r_equal;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              q_bit;

    // Numerator never exceeds the divisor; equal operands mean a gain of one.
    assign shifted = {r_rem[DATA_W-1:0], 1'b0};
    assign diff    = shifted - {1'b0, r_den};
    assign q_bit   = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= {1'b0, i_num};
            r_den   <= i_den;
            r_equal <= i_num == i_den;
            r_quot  <= '0;
        end else if (r_busy) begin
            r_rem  <= q_bit ? diff : shifted;
            r_quot <= {r_quot[QUOT_W-2:0], q_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_equal ? GAIN_ONE : {1'b0, r_quot};

endmodule

@@ rtl/skf_mul.sv @@
module skf_mul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [skf_pkg::PROD_W-1:0]   i_mcand,
    input  logic [skf_pkg::GAIN_W-1:0]   i_mplier,
    output logic                         o_done,
    output logic [skf_pkg::PROD_W-1:0]   o_prod
);
    import skf_pkg::*;

    localparam int CNT_W = $clog2(GAIN_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [PROD_W-1:0] r_acc;
    logic [PROD_W-1:0] r_mcand;
    logic [GAIN_W-1:0] r_mplier;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(GAIN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift-add, one multiplier bit per cycle; the product is exact modulo 2^PROD_W.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= i_mcand;
            r_mplier <= i_mplier;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= {r_mcand[PROD_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[GAIN_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

@@ rtl/skf_checker.sv @@
module skf_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [skf_pkg::DATA_W-1:0]   i_out_estimate,
    input  logic [skf_pkg::DATA_W-1:0]   i_out_variance,
    input  logic [skf_pkg::GAIN_W-1:0]   i_out_gain
);
    import skf_pkg::*;

    // output register is empty right after reset
    a_out_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word present right after reset");

    // one measurement at a time: ready drops after a word is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("measurement taken while the previous one is in work");

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_gain <= GAIN_ONE)
        else $error("gain above one");

    // a gain of one leaves no variance
    a_unit_gain_var: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_gain == GAIN_ONE |-> i_out_variance == '0)
        else $error("nonzero variance at unit gain");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_estimate) && $stable(i_out_variance)
            && $stable(i_out_gain))
        else $error("stalled result word changed");

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_meas.valid),
    .i_in_ready     (i_meas.ready),
    .i_out_valid    (o_est.valid),
    .i_out_ready    (o_est.ready),
    .i_out_estimate (o_est.estimate),
    .i_out_variance (o_est.variance),
    .i_out_gain     (o_est.gain)
);

@@ verif/scalar_kalman_filter_tb.sv @@
`timescale 1ns / 100ps

module scalar_kalman_filter_tb;
    import skf_pkg::*;

    localparam int          STALL_LIMIT = 4000;
    localparam int          END_WAIT    = 120;
    localparam int          MAX_PRINTS  = 40;
    localparam logic [63:0] GAIN_HALF   = 64'd32768;

    typedef struct packed {
        logic signed [DATA_W-1:0] estimate;
        logic        [DATA_W-1:0] variance;
        logic        [GAIN_W-1:0] gain;
    } est_word_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [DATA_W-1:0]    cfg_data;

    skf_meas_if meas_ch ();
    skf_est_if  est_ch ();

    scalar_kalman_filter dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_meas     (meas_ch),
        .o_est      (est_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // filter model: registers and state
    logic        [DATA_W-1:0] q_noise;
    logic        [DATA_W-1:0] r_noise;
    logic signed [DATA_W-1:0] init_est;
    logic        [DATA_W-1:0] init_var;
    logic signed [DATA_W-1:0] est_state;
    logic        [DATA_W-1:0] var_state;

    est_word_t pending_estimates[$];
    int        mismatch_count;
    int        stall_cycles;
    int        rx_stall_pct;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic est_word_t kalman_update(
        input logic signed [DATA_W-1:0] h,
        input logic        [DATA_W-1:0] p,
        input logic signed [DATA_W-1:0] z
    );
        logic [DATA_W:0]   sum;
        logic [DATA_W-1:0] pred;
        logic [DATA_W-1:0] s;
        logic [63:0]       num;
        logic [63:0]       quo;
        logic [63:0]       wgt;
        logic [63:0]       pv;
        logic [GAIN_W-1:0] g;
        longint            err;
        longint            corr;
        longint            nh;
        est_word_t         w;
        sum  = {1'b0, p} + {1'b0, q_noise};
        pred = sum[DATA_W] ? '1 : sum[DATA_W-1:0];
        sum  = {1'b0, pred} + {1'b0, r_noise};
        s    = sum[DATA_W] ? '1 : sum[DATA_W-1:0];
        num  = 64'(pred);
        num  = num << QUOT_W;
        quo  = num / 64'(s);
        g    = (quo > 64'(GAIN_ONE)) ? GAIN_ONE : quo[GAIN_W-1:0];
        err  = longint'(z) - longint'(h);
        // arithmetic shift floors, which gives round-half-up on the product
        corr = (longint'(g) * err + longint'(GAIN_HALF)) >>> QUOT_W;
        nh   = longint'(h) + corr;
        if (nh > 64'sd2147483647) nh = 64'sd2147483647;
        if (nh < -64'sd2147483648) nh = -64'sd2147483648;
        wgt  = 64'(GAIN_ONE - g);
        pv   = (wgt * 64'(pred) + GAIN_HALF) >> QUOT_W;
        if (pv > 64'hFFFF_FFFF) pv = 64'hFFFF_FFFF;
        w.estimate = nh[DATA_W-1:0];
        w.variance = pv[DATA_W-1:0];
        w.gain     = g;
        return w;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTS) $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // input monitor: predict on every accepted measurement word
    always @(posedge clk) begin
        logic signed [DATA_W-1:0] h;
        logic        [DATA_W-1:0] p;
        est_word_t                w;
        if (rst_n && meas_ch.valid && meas_ch.ready) begin
            h = meas_ch.restart ? init_est : est_state;
            p = meas_ch.restart ? init_var : var_state;
            w = kalman_update(h, p, meas_ch.measurement);
            est_state = w.estimate;
            var_state = w.variance;
            pending_estimates.push_back(w);
        end
    end

    // result checker and watchdog
    always @(posedge clk) begin
        est_word_t w;
        logic      moved;
        moved = 1'b0;
        if (rst_n && meas_ch.valid && meas_ch.ready) moved = 1'b1;
        if (rst_n && est_ch.valid && est_ch.ready) begin
            moved = 1'b1;
            if (pending_estimates.size() == 0) begin
                report_mismatch($sformatf("unexpected word est=%h var=%h gain=%h",
                    est_ch.estimate, est_ch.variance, est_ch.gain));
            end else begin
                w = pending_estimates.pop_front();
                if (est_ch.estimate !== w.estimate)
                    report_mismatch($sformatf("estimate %h, want %h",
                        est_ch.estimate, w.estimate));
                if (est_ch.variance !== w.variance)
                    report_mismatch($sformatf("variance %h, want %h",
                        est_ch.variance, w.variance));
                if (est_ch.gain !== w.gain)
                    report_mismatch($sformatf("gain %h, want %h", est_ch.gain, w.gain));
            end
        end
        if (moved) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("scalar_kalman_filter test failed");
                $finish;
            end
        end
    end

    // receiver: ready pattern with stalls whose density changes over time
    always @(negedge clk) begin
        int hold;
        int cyc;
        if (hold > 0) begin
            est_ch.ready <= 1'b0;
            hold--;
        end else begin
            est_ch.ready <= 1'b1;
            if ($urandom_range(0, 99) < rx_stall_pct) hold = $urandom_range(1, 40);
        end
        cyc++;
        if (cyc % 400 == 0) begin
            case ($urandom_range(0, 3))
                0: rx_stall_pct = 0;
                1: rx_stall_pct = 5;
                2: rx_stall_pct = 30;
                default: rx_stall_pct = 70;
            endcase
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            CFG_PROCESS_NOISE: q_noise  = data;
            CFG_MEAS_NOISE:    r_noise  = (data == '0) ? DATA_W'(1) : data;
            CFG_INIT_EST:      init_est = data;
            CFG_INIT_VAR:      init_var = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_measurement(input logic signed [DATA_W-1:0] z, input logic rflag);
        @(negedge clk);
        meas_ch.valid       <= 1'b1;
        meas_ch.measurement <= z;
        meas_ch.restart     <= rflag;
        do @(posedge clk); while (!meas_ch.ready);
    endtask

    task automatic release_sender(input int gap);
        @(negedge clk);
        meas_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
    endtask

    task automatic wait_results_drained();
        release_sender(0);
        while (pending_estimates.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_u32();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return DATA_W'($urandom_range(0, 1024));
            3: return DATA_W'($urandom_range(0, 1 << 20));
            4: return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
            default: return DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_s32();
        case ($urandom_range(0, 5))
            0: return {1'b1, {(DATA_W-1){1'b0}}};
            1: return {1'b0, {(DATA_W-1){1'b1}}};
            2: return '0;
            3: return DATA_W'($urandom_range(0, 10000 << 16));
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // mostly noisy samples around one altitude, with outliers and extremes
    function automatic logic signed [DATA_W-1:0] pick_measurement(
        input logic signed [DATA_W-1:0] base
    );
        longint v;
        int     k;
        k = $urandom_range(0, 99);
        if (k < 75) begin
            v = longint'(base) + longint'($urandom_range(0, 1 << 21)) - (1 << 20);
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            return v[DATA_W-1:0];
        end
        if (k < 88) return DATA_W'($urandom);
        if (k < 94) return {1'b1, {(DATA_W-1){1'b0}}};
        return {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

    task automatic test_default_registers();
        send_measurement('0, 1'b0);
        send_measurement({1'b0, {(DATA_W-1){1'b1}}}, 1'b0);
        send_measurement({1'b1, {(DATA_W-1){1'b0}}}, 1'b0);
        send_measurement({1'b1, {(DATA_W-1){1'b0}}}, 1'b1);
        send_measurement({1'b0, {(DATA_W-1){1'b1}}}, 1'b1);
        send_measurement(32'sh0064_8000, 1'b0);
        wait_results_drained();
    endtask

    task automatic test_noise_extremes();
        // zero variance and zero process noise: gain drops to zero
        write_reg(CFG_PROCESS_NOISE, '0);
        write_reg(CFG_MEAS_NOISE, '0);
        write_reg(CFG_INIT_EST, {1'b0, {(DATA_W-1){1'b1}}});
        write_reg(CFG_INIT_VAR, '0);
        send_measurement({1'b1, {(DATA_W-1){1'b0}}}, 1'b1);
        send_measurement('0, 1'b0);
        wait_results_drained();
        // tiny measurement noise: gain close to one
        write_reg(CFG_INIT_VAR, 32'h0001_0000);
        send_measurement({1'b1, {(DATA_W-1){1'b0}}}, 1'b1);
        send_measurement({1'b0, {(DATA_W-1){1'b1}}}, 1'b0);
        wait_results_drained();
        // both sums saturate: gain is exactly one
        write_reg(CFG_PROCESS_NOISE, '1);
        write_reg(CFG_MEAS_NOISE, '1);
        write_reg(CFG_INIT_EST, {1'b1, {(DATA_W-1){1'b0}}});
        write_reg(CFG_INIT_VAR, '1);
        send_measurement({1'b0, {(DATA_W-1){1'b1}}}, 1'b1);
        send_measurement({1'b1, {(DATA_W-1){1'b0}}}, 1'b0);
        send_measurement(32'sh1234_5678, 1'b0);
        wait_results_drained();
        // huge measurement noise against a small variance: gain near zero
        write_reg(CFG_PROCESS_NOISE, 32'd655);
        write_reg(CFG_INIT_VAR, 32'd1);
        send_measurement({1'b0, {(DATA_W-1){1'b1}}}, 1'b1);
        send_measurement({1'b1, {(DATA_W-1){1'b0}}}, 1'b0);
        wait_results_drained();
    endtask

    task automatic test_ignored_index();
        logic [CFG_IDX_W-1:0] idx;
        for (int i = CFG_INIT_VAR + 1; i < (1 << CFG_IDX_W); i++) begin
            idx = CFG_IDX_W'(i);
            write_reg(idx, DATA_W'($urandom));
        end
        write_reg(CFG_MEAS_NOISE, 32'h0001_0000);
        send_measurement(32'sh0010_0000, 1'b1);
        send_measurement(32'sh0011_0000, 1'b0);
        send_measurement(-32'sh0011_0000, 1'b0);
        wait_results_drained();
    endtask

    task automatic test_random_tracking();
        logic signed [DATA_W-1:0] base;
        logic                     rflag;
        int                       burst;
        for (int ph = 0; ph < 7; ph++) begin
            write_reg(CFG_PROCESS_NOISE, pick_u32());
            write_reg(CFG_MEAS_NOISE, pick_u32());
            write_reg(CFG_INIT_EST, pick_s32());
            write_reg(CFG_INIT_VAR, pick_u32());
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IDX_W'($urandom_range(CFG_INIT_VAR + 1, (1 << CFG_IDX_W) - 1)),
                          DATA_W'($urandom));
            base  = ($urandom_range(0, 1) == 0) ? DATA_W'($urandom_range(0, 10000 << 16))
                                                : DATA_W'($urandom);
            burst = $urandom_range(1, 20);
            for (int n = 0; n < 145; n++) begin
                rflag = (n == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 99) < 8);
                if ($urandom_range(0, 49) == 0) base = DATA_W'($urandom);
                send_measurement(pick_measurement(base), rflag);
                burst--;
                if ($urandom_range(0, 99) == 0) begin
                    // hold off until the filter has delivered every word
                    wait_results_drained();
                    burst = $urandom_range(1, 20);
                end else if (burst == 0) begin
                    release_sender($urandom_range(0, 60));
                    burst = $urandom_range(1, 20);
                end
            end
            wait_results_drained();
        end
    endtask

    initial begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_idx             = '0;
        cfg_data            = '0;
        meas_ch.valid       = 1'b0;
        meas_ch.measurement = '0;
        meas_ch.restart     = 1'b0;
        est_ch.ready        = 1'b0;
        rx_stall_pct        = 20;
        mismatch_count      = 0;
        stall_cycles        = 0;
        q_noise             = RST_PROCESS_NOISE;
        r_noise             = RST_MEAS_NOISE;
        init_est            = RST_INIT_EST;
        init_var            = RST_INIT_VAR;
        est_state           = '0;
        var_state           = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_registers();
        test_noise_extremes();
        test_ignored_index();
        test_random_tracking();

        wait_results_drained();
        repeat (END_WAIT) @(posedge clk);
        if (mismatch_count == 0 && pending_estimates.size() == 0) begin
            $display("scalar_kalman_filter test passed");
        end else begin
            $display("scalar_kalman_filter test failed");
        end
        $finish;
    end

endmodule
